### hw/rtl/hcwg_pkg.sv
package hcwg_pkg;

  // field widths
  localparam int CHAN_W   = 10;
  localparam int FRAME_W  = 40;
  localparam int TAC_W    = 2;
  localparam int FIELD_W  = 10;
  localparam int TIME_W   = 51;
  localparam int WINDOW_W = 20;
  localparam int CNT_W    = 3;

  // time base
  localparam int FRAME_CLOCKS = 1024;
  localparam int FRAME_SHIFT  = $clog2(FRAME_CLOCKS);
  localparam int WRAP_ADD     = 1024;
  localparam int WRAP_MARGIN  = 256;
  localparam int ENERGY_W     = FIELD_W + 1;

  // channel registers
  localparam int NCHREG       = 4;
  localparam int ACTIVE_RESET = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_D = 3'd5;

  typedef struct packed {
    logic [CHAN_W-1:0]  hit_channel;
    logic [FRAME_W-1:0] hit_frame;
    logic [TAC_W-1:0]   hit_tac;
    logic [FIELD_W-1:0] coarse_time;
    logic [FIELD_W-1:0] coarse_energy;
    logic [FIELD_W-1:0] fine_time;
    logic [FIELD_W-1:0] fine_energy;
  } hit_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [FRAME_W-1:0] out_frame;
    logic [TAC_W-1:0]   out_tac;
    logic [FIELD_W-1:0] out_coarse_time;
    logic [FIELD_W-1:0] out_coarse_energy;
    logic [FIELD_W-1:0] out_fine_time;
    logic [FIELD_W-1:0] out_fine_energy;
    logic [TIME_W-1:0]  end_time;
    logic               last_of_group;
  } out_item_t;

  // one stored hit per slot
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [TAC_W-1:0]   tac;
    logic [FIELD_W-1:0] coarse_time;
    logic [FIELD_W-1:0] coarse_energy;
    logic [FIELD_W-1:0] fine_time;
    logic [FIELD_W-1:0] fine_energy;
  } slot_word_t;

endpackage

### hw/rtl/hit_coincidence_window_grouper.sv
// a group-closing hit sets busy_r; the first slot read then loads the ram output register
// throughput: a hit closing no group is accepted every cycle while idle; a group of n
//   results leave one per cycle unless stalled, set by the single read port of the slot ram
// during a group drain the next hit is taken in the cycle the last slot read issues
// reset: synchronous, active low; clears slot flags, anchor, output and config to defaults;
//   the slot ram is not cleared, an entry is read only after its slot was filled
module hit_coincidence_window_grouper #(
  parameter int MAX_SLOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // hit input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hcwg_pkg::hit_item_t               in_hit,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output hcwg_pkg::out_item_t               out_result,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hcwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcwg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LIVE_MAX = (MAX_SLOTS < hcwg_pkg::NCHREG) ? MAX_SLOTS : hcwg_pkg::NCHREG;
  localparam int WORD_W   = $bits(hcwg_pkg::slot_word_t);

  // configuration registers
  logic [hcwg_pkg::WINDOW_W-1:0] window_r;
  logic [hcwg_pkg::CNT_W-1:0]    count_r;
  logic [hcwg_pkg::CHAN_W-1:0]   chan_r [hcwg_pkg::NCHREG];

  // coincidence state
  logic [hcwg_pkg::TIME_W-1:0]   anchor_r, anchor_nxt;
  logic                          seen_r;
  logic [MAX_SLOTS-1:0]          filled_r, filled_nxt;

  // drain sequencer and output stage
  logic                          busy_r, busy_nxt;
  logic [SLOT_W-1:0]             idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [hcwg_pkg::CHAN_W-1:0]   ch_r;
  logic                          last_r;

  logic                          in_fire;
  logic                          issue;
  logic                          last_issue;
  logic [hcwg_pkg::CNT_W-1:0]    live_n;

  // accept-side decode
  logic [hcwg_pkg::TIME_W-1:0]   now;
  logic [hcwg_pkg::TIME_W-1:0]   anchor_eff;
  logic [hcwg_pkg::TIME_W:0]     now_plus_win;
  logic [hcwg_pkg::TIME_W:0]     anc_plus_win;
  logic                          out_of_window;
  logic [MAX_SLOTS-1:0]          hit_vec;
  logic                          hit_found;
  logic [SLOT_W-1:0]             wr_addr;
  logic [hcwg_pkg::CNT_W-1:0]    fill_cnt;
  logic                          all_filled;
  logic                          emit;
  logic [hcwg_pkg::CHAN_W-1:0]   ch_sel;

  hcwg_pkg::slot_word_t          wr_word;
  hcwg_pkg::slot_word_t          rd_word;
  logic [hcwg_pkg::ENERGY_W-1:0] energy_ext;
  logic [WORD_W-1:0]             rd_bits;

  assign cfg_ready = 1'b1;

  // live slot count: active_count limited to the slots that exist and have a channel register
  assign live_n = (count_r > hcwg_pkg::CNT_W'(LIVE_MAX)) ?
                  hcwg_pkg::CNT_W'(LIVE_MAX) : count_r;

  // sequencer reads one slot per cycle whenever the output register frees up
  assign issue      = busy_r && (!out_valid_r || out_ready);
  assign last_issue = issue && ((hcwg_pkg::CNT_W'(idx_r) + hcwg_pkg::CNT_W'(1)) == live_n);
  // a new hit may land on the cycle the final read goes out (ram is read-first)
  assign in_ready   = !busy_r || last_issue;
  assign in_fire    = in_valid && in_ready;

  // hit time and window test against the anchor, in both directions
  assign now = (hcwg_pkg::TIME_W'(in_hit.hit_frame) << hcwg_pkg::FRAME_SHIFT)
             + hcwg_pkg::TIME_W'(in_hit.coarse_time);
  // first hit after reset becomes its own anchor, so it never clears
  assign anchor_eff    = seen_r ? anchor_r : now;
  assign now_plus_win  = {1'b0, now} + (hcwg_pkg::TIME_W + 1)'(window_r);
  assign anc_plus_win  = {1'b0, anchor_eff} + (hcwg_pkg::TIME_W + 1)'(window_r);
  assign out_of_window = ({1'b0, now} > anc_plus_win) || ({1'b0, anchor_eff} > now_plus_win);

  always_comb begin
    hit_vec    = '0;
    hit_found  = 1'b0;
    wr_addr    = '0;
    fill_cnt   = '0;
    all_filled = 1'b1;
    // lowest matching live slot takes the hit
    for (int i = 0; i < LIVE_MAX; i++) begin
      if (!hit_found && (hcwg_pkg::CNT_W'(i) < live_n) &&
          (chan_r[i] == in_hit.hit_channel)) begin
        hit_vec[i] = 1'b1;
        hit_found  = 1'b1;
        wr_addr    = SLOT_W'(i);
      end
    end
    filled_nxt = (out_of_window ? '0 : filled_r) | hit_vec;
    for (int i = 0; i < LIVE_MAX; i++) begin
      if (hcwg_pkg::CNT_W'(i) < live_n) begin
        if (filled_nxt[i]) begin
          fill_cnt = fill_cnt + hcwg_pkg::CNT_W'(1);
        end else begin
          all_filled = 1'b0;
        end
      end
    end
    // anchor tracks the hit while a single slot holds data
    anchor_nxt = (fill_cnt == hcwg_pkg::CNT_W'(1)) ? now : anchor_eff;
    emit       = (live_n != '0) && all_filled;
  end

  always_comb begin
    wr_word.frame         = in_hit.hit_frame;
    wr_word.tac           = in_hit.hit_tac;
    wr_word.coarse_time   = in_hit.coarse_time;
    wr_word.coarse_energy = in_hit.coarse_energy;
    wr_word.fine_time     = in_hit.fine_time;
    wr_word.fine_energy   = in_hit.fine_energy;
  end

  // channel number for the slot being read
  always_comb begin
    ch_sel = '0;
    for (int i = 0; i < hcwg_pkg::NCHREG; i++) begin
      if (hcwg_pkg::CNT_W'(i) == hcwg_pkg::CNT_W'(idx_r)) begin
        ch_sel = chan_r[i];
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + SLOT_W'(1);
      if (last_issue) begin
        busy_nxt = 1'b0;
      end
    end
    // a hit that completes the group starts a fresh drain from slot zero
    if (in_fire && emit) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '0;
      count_r     <= hcwg_pkg::CNT_W'(hcwg_pkg::ACTIVE_RESET);
      for (int i = 0; i < hcwg_pkg::NCHREG; i++) begin
        chan_r[i] <= '0;
      end
      anchor_r    <= '0;
      seen_r      <= 1'b0;
      filled_r    <= '0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hcwg_pkg::CFG_WINDOW: window_r  <= cfg_data[hcwg_pkg::WINDOW_W-1:0];
          hcwg_pkg::CFG_COUNT:  count_r   <= cfg_data[hcwg_pkg::CNT_W-1:0];
          hcwg_pkg::CFG_CHAN_A: chan_r[0] <= cfg_data[hcwg_pkg::CHAN_W-1:0];
          hcwg_pkg::CFG_CHAN_B: chan_r[1] <= cfg_data[hcwg_pkg::CHAN_W-1:0];
          hcwg_pkg::CFG_CHAN_C: chan_r[2] <= cfg_data[hcwg_pkg::CHAN_W-1:0];
          hcwg_pkg::CFG_CHAN_D: chan_r[3] <= cfg_data[hcwg_pkg::CHAN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        anchor_r <= anchor_nxt;
        seen_r   <= 1'b1;
        filled_r <= filled_nxt;
      end
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // side data travelling with the ram read
  always_ff @(posedge clk) begin
    if (issue) begin
      ch_r   <= ch_sel;
      last_r <= last_issue;
    end
  end

  // slot storage; its read register doubles as the output register
  hcwg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (in_fire && hit_found),
    .waddr (wr_addr),
    .wdata (wr_word),
    .re    (issue),
    .raddr (idx_r),
    .rdata (rd_bits)
  );

  assign rd_word = rd_bits;

  // end of pulse wraps into the next frame when it lies well below the start
  assign energy_ext =
    (({1'b0, rd_word.coarse_energy} + hcwg_pkg::ENERGY_W'(hcwg_pkg::WRAP_MARGIN)) <
     {1'b0, rd_word.coarse_time}) ?
    ({1'b0, rd_word.coarse_energy} + hcwg_pkg::ENERGY_W'(hcwg_pkg::WRAP_ADD)) :
    {1'b0, rd_word.coarse_energy};

  assign out_valid = out_valid_r;

  always_comb begin
    out_result.out_channel       = ch_r;
    out_result.out_frame         = rd_word.frame;
    out_result.out_tac           = rd_word.tac;
    out_result.out_coarse_time   = rd_word.coarse_time;
    out_result.out_coarse_energy = rd_word.coarse_energy;
    out_result.out_fine_time     = rd_word.fine_time;
    out_result.out_fine_energy   = rd_word.fine_energy;
    out_result.end_time          =
      (hcwg_pkg::TIME_W'(rd_word.frame) << hcwg_pkg::FRAME_SHIFT) +
      hcwg_pkg::TIME_W'(energy_ext);
    out_result.last_of_group     = last_r;
  end

endmodule

### hw/rtl/hcwg_ram.sv
module hcwg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write to the same entry return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/hcwg_checker.sv
module hcwg_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hcwg_pkg::out_item_t out_result
);

  // reset empties the output
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

  // a group drains without gaps while the sink takes results
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_result.last_of_group |=> out_valid)
    else $error("group result missing after non-final transaction");

  // end time keeps the stored coarse energy in its low bits
  a_end_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.end_time[9:0] == out_result.out_coarse_energy)
    else $error("end time low bits disagree with coarse energy");

endmodule

bind hit_coincidence_window_grouper hcwg_checker u_hcwg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_result (out_result)
);

### test/hit_coincidence_window_grouper_tb.sv
`timescale 1ns / 100ps

module hit_coincidence_window_grouper_tb;

  // time base of the detector, independent of the block's own constants
  localparam int FRAME_TICKS  = 1024;
  localparam int ENERGY_WRAP  = 1024;
  localparam int LATE_MARGIN  = 256;
  localparam int WIDE_W       = hcwg_pkg::FIELD_W + 1;
  localparam int HT_W         = hcwg_pkg::FRAME_W + hcwg_pkg::FIELD_W;

  // register indexes that map to no register
  localparam logic [hcwg_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [hcwg_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [hcwg_pkg::FRAME_W-1:0]    FRAME_MAX  = {hcwg_pkg::FRAME_W{1'b1}};
  localparam logic [hcwg_pkg::CFG_DATA_W-1:0] WINDOW_MAX = {hcwg_pkg::WINDOW_W{1'b1}};

  // quiet cycles after the last result before touching registers or ending
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_NS     = 2_000_000;

  // -------------------------------------------------------------------------
  // scoreboard: mirrors the grouper state and holds the results still owed
  // -------------------------------------------------------------------------
  class coincidence_scoreboard;
    logic [hcwg_pkg::WINDOW_W-1:0] window;
    logic [hcwg_pkg::CNT_W-1:0]    active;
    logic [hcwg_pkg::CHAN_W-1:0]   chan [hcwg_pkg::NCHREG];
    logic [hcwg_pkg::TIME_W-1:0]   anchor;
    bit                            seen;
    bit                            filled [hcwg_pkg::NCHREG];
    hcwg_pkg::slot_word_t          slot [hcwg_pkg::NCHREG];
    hcwg_pkg::out_item_t           pending_results [$];
    int                            hits;
    int                            checked;
    int                            groups;
    int                            errors;

    function new();
      window = '0;
      active = hcwg_pkg::CNT_W'(hcwg_pkg::ACTIVE_RESET);
      anchor = '0;
      seen = 1'b0;
      foreach (chan[i]) begin
        chan[i] = '0;
        filled[i] = 1'b0;
      end
      hits = 0;
      checked = 0;
      groups = 0;
      errors = 0;
    endfunction

    // active count clamps to the number of slots
    function int live_slots();
      return (active > hcwg_pkg::NCHREG) ? hcwg_pkg::NCHREG : int'(active);
    endfunction

    function void write_reg(logic [hcwg_pkg::CFG_IDX_W-1:0] idx,
                            logic [hcwg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        hcwg_pkg::CFG_WINDOW: window = data[hcwg_pkg::WINDOW_W-1:0];
        hcwg_pkg::CFG_COUNT:  active = data[hcwg_pkg::CNT_W-1:0];
        hcwg_pkg::CFG_CHAN_A, hcwg_pkg::CFG_CHAN_B,
        hcwg_pkg::CFG_CHAN_C, hcwg_pkg::CFG_CHAN_D: begin
          chan[idx - hcwg_pkg::CFG_CHAN_A] = data[hcwg_pkg::CHAN_W-1:0];
        end
        default: ;
      endcase
    endfunction

    // apply one accepted hit and queue the group it releases, if any
    function void take_hit(hcwg_pkg::hit_item_t h);
      logic [hcwg_pkg::TIME_W-1:0] now;
      logic [hcwg_pkg::TIME_W-1:0] gap;
      logic [WIDE_W-1:0]           energy;
      hcwg_pkg::out_item_t         r;
      int                          n;
      int                          nfill;
      bit                          all_in;
      n = live_slots();
      hits++;
      now = hcwg_pkg::TIME_W'({h.hit_frame, h.coarse_time});
      if (!seen) begin
        anchor = now;
        seen = 1'b1;
      end
      gap = (now >= anchor) ? now - anchor : anchor - now;
      if (gap > window) begin
        foreach (filled[i]) filled[i] = 1'b0;
      end
      // only the lowest matching slot takes the hit
      for (int i = 0; i < n; i++) begin
        if (chan[i] == h.hit_channel) begin
          filled[i] = 1'b1;
          slot[i] = '{h.hit_frame, h.hit_tac, h.coarse_time, h.coarse_energy,
                      h.fine_time, h.fine_energy};
          break;
        end
      end
      nfill = 0;
      all_in = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (filled[i]) nfill++;
        else all_in = 1'b0;
      end
      if (nfill == 1) anchor = now;
      if (n == 0 || !all_in) return;
      groups++;
      for (int i = 0; i < n; i++) begin
        energy = {1'b0, slot[i].coarse_energy};
        // end of pulse wrapped into the next frame
        if (int'(slot[i].coarse_energy) + LATE_MARGIN < int'(slot[i].coarse_time)) begin
          energy = energy + WIDE_W'(ENERGY_WRAP);
        end
        r.out_channel       = chan[i];
        r.out_frame         = slot[i].frame;
        r.out_tac           = slot[i].tac;
        r.out_coarse_time   = slot[i].coarse_time;
        r.out_coarse_energy = slot[i].coarse_energy;
        r.out_fine_time     = slot[i].fine_time;
        r.out_fine_energy   = slot[i].fine_energy;
        r.end_time          = hcwg_pkg::TIME_W'(slot[i].frame) * FRAME_TICKS + energy;
        r.last_of_group     = (i == n - 1);
        pending_results = {pending_results, r};
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(hcwg_pkg::out_item_t got);
      hcwg_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result on channel %0d", got.out_channel);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare("out_channel", 64'(want.out_channel), 64'(got.out_channel));
      compare("out_frame", 64'(want.out_frame), 64'(got.out_frame));
      compare("out_tac", 64'(want.out_tac), 64'(got.out_tac));
      compare("out_coarse_time", 64'(want.out_coarse_time),
              64'(got.out_coarse_time));
      compare("out_coarse_energy", 64'(want.out_coarse_energy),
              64'(got.out_coarse_energy));
      compare("out_fine_time", 64'(want.out_fine_time), 64'(got.out_fine_time));
      compare("out_fine_energy", 64'(want.out_fine_energy),
              64'(got.out_fine_energy));
      compare("end_time", 64'(want.end_time), 64'(got.end_time));
      compare("last_of_group", 64'(want.last_of_group), 64'(got.last_of_group));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // block under test
  // -------------------------------------------------------------------------
  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  hcwg_pkg::hit_item_t             in_hit;
  logic                            out_valid;
  logic                            out_ready;
  hcwg_pkg::out_item_t             out_result;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [hcwg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hcwg_pkg::CFG_DATA_W-1:0] cfg_data;

  // set during the stretch where neither side idles
  bit                              steady = 1'b0;
  int                              reg_writes = 0;

  coincidence_scoreboard sb = new();

  hit_coincidence_window_grouper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_hit     (in_hit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: stall with a chance of about 37 percent outside the steady stretch
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // every result transaction is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_result);
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("hit_coincidence_window_grouper: mismatch");
    $finish;
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  function automatic hcwg_pkg::hit_item_t hit_of(
      input logic [hcwg_pkg::CHAN_W-1:0]  ch,
      input logic [hcwg_pkg::FRAME_W-1:0] fr,
      input logic [hcwg_pkg::FIELD_W-1:0] tc,
      input logic [hcwg_pkg::FIELD_W-1:0] ec,
      input logic [hcwg_pkg::FIELD_W-1:0] tf,
      input logic [hcwg_pkg::FIELD_W-1:0] ef,
      input logic [hcwg_pkg::TAC_W-1:0]   tac);
    hcwg_pkg::hit_item_t h;
    h.hit_channel   = ch;
    h.hit_frame     = fr;
    h.hit_tac       = tac;
    h.coarse_time   = tc;
    h.coarse_energy = ec;
    h.fine_time     = tf;
    h.fine_energy   = ef;
    return h;
  endfunction

  // t is the hit time in clocks: frame in the upper bits, coarse time below
  function automatic hcwg_pkg::hit_item_t rand_hit(input logic [hcwg_pkg::CHAN_W-1:0] ch,
                                                   input logic [HT_W-1:0] t);
    return hit_of(ch, t[HT_W-1:hcwg_pkg::FIELD_W], t[hcwg_pkg::FIELD_W-1:0],
                  hcwg_pkg::FIELD_W'($urandom_range(1023)),
                  hcwg_pkg::FIELD_W'($urandom_range(1023)),
                  hcwg_pkg::FIELD_W'($urandom_range(1023)),
                  hcwg_pkg::TAC_W'($urandom_range(3)));
  endfunction

  // valid stays high straight into the next transaction unless a gap is drawn
  task automatic send_hit(input hcwg_pkg::hit_item_t h);
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_hit <= h;
    do @(posedge clk); while (!in_ready);
    sb.take_hit(h);
  endtask

  // hold the sender until every owed result is out, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [hcwg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hcwg_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic apply_config(input logic [hcwg_pkg::CFG_DATA_W-1:0] win,
                              input logic [hcwg_pkg::CFG_DATA_W-1:0] cnt,
                              input logic [hcwg_pkg::CFG_DATA_W-1:0] a,
                              input logic [hcwg_pkg::CFG_DATA_W-1:0] b,
                              input logic [hcwg_pkg::CFG_DATA_W-1:0] c,
                              input logic [hcwg_pkg::CFG_DATA_W-1:0] d);
    drain_results();
    cfg_write(hcwg_pkg::CFG_WINDOW, win);
    cfg_write(hcwg_pkg::CFG_COUNT, cnt);
    cfg_write(hcwg_pkg::CFG_CHAN_A, a);
    cfg_write(hcwg_pkg::CFG_CHAN_B, b);
    cfg_write(hcwg_pkg::CFG_CHAN_C, c);
    cfg_write(hcwg_pkg::CFG_CHAN_D, d);
  endtask

  task automatic ascending_config(input logic [hcwg_pkg::CFG_DATA_W-1:0] win,
                                  input logic [hcwg_pkg::CFG_DATA_W-1:0] cnt);
    int a;
    int b;
    int c;
    int d;
    a = $urandom_range(200);
    b = a + 1 + $urandom_range(200);
    c = b + 1 + $urandom_range(200);
    d = c + 1 + $urandom_range(200);
    apply_config(win, cnt, hcwg_pkg::CFG_DATA_W'(a), hcwg_pkg::CFG_DATA_W'(b),
                 hcwg_pkg::CFG_DATA_W'(c), hcwg_pkg::CFG_DATA_W'(d));
  endtask

  // mostly hits on active channels clustered around a moving base time,
  // with some stray channels, occasional jumps that clear the slots and
  // occasional pauses until the output side has caught up
  task automatic random_burst(input int items, input int span);
    logic [HT_W-1:0]             base;
    logic [HT_W-1:0]             t;
    logic [hcwg_pkg::CHAN_W-1:0] ch;
    int                          n;
    int                          roll;
    base = HT_W'({$urandom, $urandom});
    for (int k = 0; k < items; k++) begin
      n = sb.live_slots();
      roll = $urandom_range(99);
      if (roll < 8) base = HT_W'({$urandom, $urandom});
      if (roll < 85 && n > 0) ch = sb.chan[$urandom_range(n - 1)];
      else ch = hcwg_pkg::CHAN_W'($urandom_range(1023));
      t = base + HT_W'($urandom_range(span));
      send_hit(rand_hit(ch, t));
      if ($urandom_range(99) < 4) drain_results();
    end
  endtask

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------
  initial begin
    int win;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_hit <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= hcwg_pkg::CFG_WINDOW;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: every slot on channel zero, so only the lowest fills;
    // the very first hit sets the anchor
    send_hit(hit_of(10'd0, 40'd77, 10'd3, 10'd40, 10'd1, 10'd2, 2'd1));
    send_hit(hit_of(10'd0, 40'd77, 10'd3, 10'd41, 10'd3, 10'd4, 2'd2));

    // four ascending channels, top frame, field extremes and the wrap boundary
    apply_config(20'd64, 20'd4, 20'd3, 20'd7, 20'd12, 20'd1023);
    send_hit(hit_of(10'd3, FRAME_MAX, 10'd1000, 10'd0, 10'd0, 10'd1023, 2'd0));
    send_hit(hit_of(10'd7, FRAME_MAX, 10'd1010, 10'd1023, 10'd1023, 10'd0, 2'd1));
    // energy exactly the margin below time: no wrap
    send_hit(hit_of(10'd12, FRAME_MAX, 10'd1023, 10'd767, 10'd512, 10'd511, 2'd2));
    // one clock past the margin: wraps, and closes the group
    send_hit(hit_of(10'd1023, FRAME_MAX, 10'd990, 10'd733, 10'd341, 10'd682, 2'd3));
    // stray channel while full still releases the group
    send_hit(hit_of(10'd500, FRAME_MAX, 10'd1000, 10'd9, 10'd9, 10'd9, 2'd0));
    // refill one slot in place
    send_hit(hit_of(10'd7, FRAME_MAX, 10'd1005, 10'd100, 10'd200, 10'd300, 2'd3));
    // far away in time: slots clear
    send_hit(hit_of(10'd3, 40'd0, 10'd0, 10'd5, 10'd6, 10'd7, 2'd1));

    // zero window, single slot: every hit on the channel is its own group
    apply_config(20'd0, 20'd1, 20'd0, 20'd0, 20'd0, 20'd0);
    send_hit(hit_of(10'd0, 40'd0, 10'd0, 10'd0, 10'd0, 10'd0, 2'd0));
    send_hit(hit_of(10'd0, 40'd1, 10'd5, 10'd300, 10'd11, 10'd22, 2'd2));
    send_hit(hit_of(10'd1, 40'd1, 10'd5, 10'd33, 10'd44, 10'd55, 2'd1));

    // count above the slot limit, widest window, channels out of order,
    // upper data bits set on the channel writes
    apply_config(WINDOW_MAX, 20'd7, {10'h3FF, 10'd900}, {10'h2AA, 10'd4},
                 {10'h155, 10'd500}, {10'h3FF, 10'd0});
    send_hit(hit_of(10'd0, 40'h55_5555_5555, 10'd100, 10'd900, 10'd1, 10'd2, 2'd0));
    send_hit(hit_of(10'd500, 40'h55_5555_5555, 10'd120, 10'd50, 10'd3, 10'd4, 2'd1));
    send_hit(hit_of(10'd4, 40'h55_5555_5556, 10'd10, 10'd60, 10'd5, 10'd6, 2'd2));
    send_hit(hit_of(10'd900, 40'h55_5555_5556, 10'd900, 10'd70, 10'd7, 10'd8, 2'd3));
    send_hit(hit_of(10'd900, 40'h55_5555_5D56, 10'd0, 10'd80, 10'd9, 10'd10, 2'd0));

    // no active slots, plus writes to unmapped indexes that must be ignored
    apply_config(20'd5, 20'd0, 20'd900, 20'd901, 20'd902, 20'd903);
    cfg_write(CFG_SPARE_LO, hcwg_pkg::CFG_DATA_W'($urandom));
    cfg_write(CFG_SPARE_HI, hcwg_pkg::CFG_DATA_W'($urandom));
    send_hit(hit_of(10'd900, 40'd9, 10'd9, 10'd9, 10'd9, 10'd9, 2'd1));

    // random: moderate window, four ordered slots
    win = $urandom_range(50, 3000);
    ascending_config(hcwg_pkg::CFG_DATA_W'(win), 20'd4);
    random_burst(25, win + win / 4);

    // random: zero window, two slots, hits land on identical times
    ascending_config(20'd0, 20'd2);
    random_burst(15, 0);

    // random: no idling on either side, widest window, three slots
    ascending_config(WINDOW_MAX, 20'd3);
    steady = 1'b1;
    random_burst(25, 2000);
    drain_results();
    steady = 1'b0;

    // random: everything drawn, duplicates and disorder included
    apply_config(hcwg_pkg::CFG_DATA_W'($urandom), hcwg_pkg::CFG_DATA_W'($urandom),
                 hcwg_pkg::CFG_DATA_W'($urandom), hcwg_pkg::CFG_DATA_W'($urandom),
                 hcwg_pkg::CFG_DATA_W'($urandom), hcwg_pkg::CFG_DATA_W'($urandom));
    random_burst(25, $urandom_range(4096));

    drain_results();

    $display("covered %0d hits, %0d groups, %0d results checked, %0d register writes",
             sb.hits, sb.groups, sb.checked, reg_writes);
    $display("settings spanned zero to full window, zero to seven slots, odd channels");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("hit_coincidence_window_grouper: match");
    end else begin
      $display("hit_coincidence_window_grouper: mismatch");
    end
    $finish;
  end

endmodule

### hit_coincidence_window_grouper.f
hw/rtl/hcwg_pkg.sv
hw/rtl/hcwg_ram.sv
hw/rtl/hit_coincidence_window_grouper.sv
hw/rtl/hcwg_checker.sv
test/hit_coincidence_window_grouper_tb.sv
